>>> rtl/core/ilid_pkg.sv
// Shared constants, codes and types for the indexed list block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package ilid_pkg;

	localparam int CAPACITY = 64;                 // entries the list can hold
	localparam int IDX_W    = $clog2(CAPACITY);   // bits to address one entry
	localparam int CNT_W    = 7;                  // entry count as reported
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;

	// stream payload layout
	localparam int S_DATA_W = 40;                 // position, value
	localparam int M_DATA_W = 48;                 // read_value, status, count, pad

	localparam logic [OP_W-1:0] OP_READ     = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [VAL_W-1:0] NO_VALUE = '1;

	// one list update, applied at the clock edge
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} ilid_cmd_t;

endpackage

>>> rtl/core/ilid_list.sv
// Row of list cells with a per-cell shift multiplexer and a read port.
// Depends on ilid_pkg.
module ilid_list (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ilid_pkg::ilid_cmd_t           cmd,
	input  logic [ilid_pkg::IDX_W-1:0]    rd_idx,
	output logic [ilid_pkg::VAL_W-1:0]    rd_data,
	output logic [ilid_pkg::CNT_W-1:0]    count
);

	logic [ilid_pkg::VAL_W-1:0] cell_q [ilid_pkg::CAPACITY];
	logic [ilid_pkg::CNT_W-1:0] count_q;

	// each cell picks: keep, new value, its lower neighbor (insert) or upper (delete)
	always_ff @(posedge clk) begin
		for (int i = 0; i < ilid_pkg::CAPACITY; i++) begin
			if (cmd.ins) begin
				if (i == int'(cmd.idx)) begin
					cell_q[i] <= cmd.value;
				end else if (i > int'(cmd.idx)) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.del) begin
				if (i >= int'(cmd.idx) && i < ilid_pkg::CAPACITY - 1) begin
					cell_q[i] <= cell_q[(i < ilid_pkg::CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.del) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign rd_data = cell_q[rd_idx];
	assign count   = count_q;

endmodule

>>> rtl/core/indexed_list_insert_delete.sv
// Top level of the indexed ordered list: stream ports, input and result registers.
// Depends on ilid_pkg and ilid_list.
//
//   channel  | dir | beat carries
//   ---------+-----+---------------------------------------------------------
//   s_*      | in  | tuser: op; tdata: position, value
//   m_*      | out | tdata: read_value, status, count (entry count after op)
//
// Each op passes the cell row once: a beat is captured in the input register, then
// the cell multiplexers shift the list and the result register loads at the same
// edge, so one beat per cycle is sustained while the output is not stalled.
// Reset empties the list at once; cell contents are left as they are.
// A stalled output holds the result and one further beat in the input register.
module indexed_list_insert_delete (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ilid_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] position, [39:8] value
	input  logic [ilid_pkg::OP_W-1:0]      s_tuser,   // [2:0] op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ilid_pkg::M_DATA_W-1:0]  m_tdata    // [31:0] read_value, [33:32] status,
	                                                   // [40:34] count, [47:41] zero
);

	// input register
	logic                          vld_s1;
	logic [ilid_pkg::OP_W-1:0]     op_s1;
	logic [ilid_pkg::POS_W-1:0]    pos_s1;
	logic [ilid_pkg::VAL_W-1:0]    val_s1;

	// result register
	logic                          out_vld_q;
	logic [ilid_pkg::VAL_W-1:0]    rd_val_q;
	logic [ilid_pkg::ST_W-1:0]     status_q;
	logic [ilid_pkg::CNT_W-1:0]    count_q;

	logic                          advance;
	logic [ilid_pkg::CNT_W-1:0]    cnt;
	logic [ilid_pkg::VAL_W-1:0]    cell_rd;
	logic                          pos_neg;
	logic                          in_range;
	logic                          past_end;
	logic                          full;
	ilid_pkg::ilid_cmd_t           cmd;
	logic [ilid_pkg::VAL_W-1:0]    rd_val_d;
	logic [ilid_pkg::ST_W-1:0]     status_d;
	logic [ilid_pkg::CNT_W-1:0]    count_d;

	// advance when the result register is free or being drained
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			pos_s1 <= s_tdata[ilid_pkg::POS_W-1:0];
			val_s1 <= s_tdata[ilid_pkg::POS_W +: ilid_pkg::VAL_W];
		end
	end

	// position checks against the count before this op
	assign pos_neg  = pos_s1[ilid_pkg::POS_W-1];
	assign in_range = !pos_neg && (pos_s1[ilid_pkg::CNT_W-1:0] < cnt);
	assign past_end = !pos_neg && (pos_s1[ilid_pkg::CNT_W-1:0] > cnt);
	assign full     = (cnt >= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY));

	always_comb begin
		cmd.ins   = 1'b0;
		cmd.del   = 1'b0;
		cmd.idx   = pos_s1[ilid_pkg::IDX_W-1:0];
		cmd.value = val_s1;
		rd_val_d  = ilid_pkg::NO_VALUE;
		status_d  = ilid_pkg::ST_DONE;
		unique case (op_s1)
			ilid_pkg::OP_READ: begin
				if (in_range) begin
					rd_val_d = cell_rd;
				end else begin
					status_d = ilid_pkg::ST_RANGE;
				end
			end
			ilid_pkg::OP_INS_HEAD: begin
				cmd.idx = '0;
				if (full) begin
					status_d = ilid_pkg::ST_FULL;
				end else begin
					cmd.ins = advance;
				end
			end
			ilid_pkg::OP_INS_TAIL: begin
				cmd.idx = cnt[ilid_pkg::IDX_W-1:0];
				if (full) begin
					status_d = ilid_pkg::ST_FULL;
				end else begin
					cmd.ins = advance;
				end
			end
			ilid_pkg::OP_INS_AT: begin
				// negative position means the head; range check comes before full
				if (pos_neg) begin
					cmd.idx = '0;
				end
				if (past_end) begin
					status_d = ilid_pkg::ST_RANGE;
				end else if (full) begin
					status_d = ilid_pkg::ST_FULL;
				end else begin
					cmd.ins = advance;
				end
			end
			ilid_pkg::OP_DELETE: begin
				if (in_range) begin
					cmd.del = advance;
				end else begin
					status_d = ilid_pkg::ST_RANGE;
				end
			end
			default: begin
				// unused op codes: no change, nothing read
			end
		endcase
	end

	assign count_d = cnt + ilid_pkg::CNT_W'(cmd.ins) - ilid_pkg::CNT_W'(cmd.del);

	ilid_list u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (pos_s1[ilid_pkg::IDX_W-1:0]),
		.rd_data (cell_rd),
		.count   (cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_val_q <= rd_val_d;
			status_q <= status_d;
			count_q  <= count_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(ilid_pkg::M_DATA_W - ilid_pkg::VAL_W - ilid_pkg::ST_W
		- ilid_pkg::CNT_W){1'b0}}, count_q, status_q, rd_val_q};

endmodule

>>> rtl/core/ilid_checker.sv
// Port-level checker for the indexed list, bound to the top level.
// Depends on ilid_pkg and indexed_list_insert_delete.
module ilid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ilid_pkg::M_DATA_W-1:0]  m_tdata
);

	logic [ilid_pkg::VAL_W-1:0] rd_val;
	logic [ilid_pkg::ST_W-1:0]  status;
	logic [ilid_pkg::CNT_W-1:0] count;
	logic                       seen_q;
	logic [ilid_pkg::CNT_W-1:0] last_count_q;

	assign rd_val = m_tdata[ilid_pkg::VAL_W-1:0];
	assign status = m_tdata[ilid_pkg::VAL_W +: ilid_pkg::ST_W];
	assign count  = m_tdata[ilid_pkg::VAL_W + ilid_pkg::ST_W +: ilid_pkg::CNT_W];

	// remember the count of the last result beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_count_q <= '0;
		end else if (m_tvalid && m_tready) begin
			seen_q       <= 1'b1;
			last_count_q <= count;
		end
	end

	// count never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> count <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
		else $error("count above capacity");

	// a full drop reports a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == ilid_pkg::ST_FULL
		|-> count == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
		else $error("full status with list not full");

	// a rejected op reads nothing
	a_reject_novalue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == ilid_pkg::ST_RANGE || status == ilid_pkg::ST_FULL)
		|-> rd_val == ilid_pkg::NO_VALUE)
		else $error("value returned for rejected op");

	// count moves by at most one between consecutive result beats
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_q
		|-> count == last_count_q
			|| count == last_count_q + ilid_pkg::CNT_W'(1)
			|| count == last_count_q - ilid_pkg::CNT_W'(1))
		else $error("count jumped between result beats");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (.*);

>>> bench/tb_indexed_list_insert_delete.sv
`timescale 1ns / 100ps
// Self-checking bench for indexed_list_insert_delete: a short table of directed ops, then
// biased random ops with idle and stall patterns on both stream ports.
// Depends on ilid_pkg and the block's RTL; results are checked against an in-bench list model.
module tb_indexed_list_insert_delete;

	localparam int STALL_LIMIT      = 3000;   // cycles with no beat on either port
	localparam int PRESSURE_HOLD    = 300;    // long output hold-off, in cycles
	localparam int RANDOM_PER_PHASE = 470;
	localparam int TREND_LEN        = 125;    // ops per grow / mixed / shrink stretch
	localparam int DRAIN_CYCLES     = 8;      // allow margin after the last result
	localparam int N_DIRECTED       = 25;

	typedef enum int {
		TREND_GROW,
		TREND_MIXED,
		TREND_SHRINK
	} trend_t;

	// one result beat, unpacked from m_tdata
	typedef struct packed {
		logic [ilid_pkg::VAL_W-1:0] read_value;
		logic [ilid_pkg::ST_W-1:0]  status;
		logic [ilid_pkg::CNT_W-1:0] count;
	} list_result_t;

	// directed row: fixed = 1 means the result below is typed in, else predicted
	typedef struct packed {
		logic [ilid_pkg::OP_W-1:0]  op;
		logic [ilid_pkg::POS_W-1:0] position;
		logic [ilid_pkg::VAL_W-1:0] value;
		logic                       fixed;
		list_result_t               result;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
		// empty list: reads, deletes and a past-the-tail insert are all out of range
		'{ilid_pkg::OP_READ,     8'h00, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd0}},
		'{ilid_pkg::OP_DELETE,   8'h00, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd0}},
		'{ilid_pkg::OP_INS_AT,   8'h01, 32'h1111_1111, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd0}},
		// position zero on an empty list is head and tail at once
		'{ilid_pkg::OP_INS_AT,   8'h00, 32'h1234_5678, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd1}},
		'{ilid_pkg::OP_INS_HEAD, 8'h3c, 32'h7fff_ffff, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd2}},
		'{ilid_pkg::OP_INS_TAIL, 8'hc3, 32'h8000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd3}},
		// most negative position folds to the head
		'{ilid_pkg::OP_INS_AT,   8'h80, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd4}},
		// position equal to the count appends
		'{ilid_pkg::OP_INS_AT,   8'h04, 32'hffff_ffff, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd5}},
		'{ilid_pkg::OP_INS_AT,   8'h7f, 32'h5555_5555, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd5}},
		'{ilid_pkg::OP_INS_AT,   8'h02, 32'ha5a5_a5a5, 1'b0, '0},
		'{ilid_pkg::OP_READ,     8'h00, 32'hffff_ffff, 1'b0, '0},
		'{ilid_pkg::OP_READ,     8'h01, 32'h0000_0000, 1'b0, '0},
		'{ilid_pkg::OP_READ,     8'h05, 32'h0000_0000, 1'b0, '0},
		'{ilid_pkg::OP_READ,     8'h06, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		'{ilid_pkg::OP_READ,     8'hff, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		'{ilid_pkg::OP_READ,     8'h7f, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		'{ilid_pkg::OP_READ,     8'h80, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		'{ilid_pkg::OP_DELETE,   8'h7f, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		'{ilid_pkg::OP_DELETE,   8'h80, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_RANGE, 7'd6}},
		// delete the head, then the tail
		'{ilid_pkg::OP_DELETE,   8'h00, 32'h0000_0000, 1'b0, '0},
		'{ilid_pkg::OP_DELETE,   8'h04, 32'h0000_0000, 1'b0, '0},
		// unused op codes do nothing but report the count
		'{3'd5,                  8'h55, 32'hdead_beef, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd4}},
		'{3'd6,                  8'haa, 32'h0000_0000, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd4}},
		'{3'd7,                  8'hff, 32'hffff_ffff, 1'b1,
			'{ilid_pkg::NO_VALUE, ilid_pkg::ST_DONE,  7'd4}},
		'{ilid_pkg::OP_READ,     8'h03, 32'h0000_0000, 1'b0, '0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [ilid_pkg::S_DATA_W-1:0] s_tdata;    // [7:0] position, [39:8] value
	logic [ilid_pkg::OP_W-1:0]     s_tuser;    // [2:0] op
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ilid_pkg::M_DATA_W-1:0] m_tdata;    // [31:0] read_value, [33:32] status,
	                                           // [40:34] count, [47:41] zero

	// list model state
	logic [ilid_pkg::VAL_W-1:0] list_store [ilid_pkg::CAPACITY];
	int                         list_len;

	list_result_t     pending_results [$];

	int send_idle_pct;
	int recv_idle_pct;
	int pressure_req = 0;
	int pressure_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int op_beats = 0;
	int result_beats = 0;
	int full_drops = 0;
	int range_ignores = 0;
	int peak_len = 0;
	int backpressure_cycles = 0;

	indexed_list_insert_delete i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Place v at slot at (0..list_len), shifting the tail up; refuse when full.
	function automatic logic [ilid_pkg::ST_W-1:0] place_entry(int at,
			logic [ilid_pkg::VAL_W-1:0] v);
		if (list_len >= ilid_pkg::CAPACITY)
			return ilid_pkg::ST_FULL;
		for (int i = list_len; i > at; i--)
			list_store[i] = list_store[i-1];
		list_store[at] = v;
		list_len++;
		return ilid_pkg::ST_DONE;
	endfunction

	// Apply one op to the list model and return the result beat it must produce.
	function automatic list_result_t apply_list_op(logic [ilid_pkg::OP_W-1:0] op,
			logic signed [ilid_pkg::POS_W-1:0] pos, logic [ilid_pkg::VAL_W-1:0] v);
		list_result_t r;
		int           p;
		p = int'(pos);
		r.read_value = ilid_pkg::NO_VALUE;
		r.status = ilid_pkg::ST_DONE;
		case (op)
			ilid_pkg::OP_READ: begin
				if (p < 0 || p >= list_len)
					r.status = ilid_pkg::ST_RANGE;
				else
					r.read_value = list_store[p];
			end
			ilid_pkg::OP_INS_HEAD: r.status = place_entry(0, v);
			ilid_pkg::OP_INS_TAIL: r.status = place_entry(list_len, v);
			ilid_pkg::OP_INS_AT: begin
				// the past-the-tail check wins over the full check
				if (p > list_len)
					r.status = ilid_pkg::ST_RANGE;
				else
					r.status = place_entry((p <= 0) ? 0 : p, v);
			end
			ilid_pkg::OP_DELETE: begin
				if (p < 0 || p >= list_len) begin
					r.status = ilid_pkg::ST_RANGE;
				end else begin
					for (int i = p; i + 1 < list_len; i++)
						list_store[i] = list_store[i+1];
					list_len--;
				end
			end
			default: ;
		endcase
		r.count = list_len[ilid_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Draw one random op. Most ops are in range for the current length; the trend
	// decides whether the list tends to fill up, drain or wander.
	function automatic void draw_op(input trend_t trend,
			output logic [ilid_pkg::OP_W-1:0] op,
			output logic [ilid_pkg::POS_W-1:0] pos,
			output logic [ilid_pkg::VAL_W-1:0] v);
		int roll;
		int ins_pct;
		int del_pct;
		v = $urandom;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: v = '0;
				1: v = '1;
				2: v = 32'h7fff_ffff;
				default: v = 32'h8000_0000;
			endcase
		end
		pos = ilid_pkg::POS_W'($urandom);
		// noise: any op code, any position
		if ($urandom_range(99) < 8) begin
			op = ilid_pkg::OP_W'($urandom_range(7));
			return;
		end
		case (trend)
			TREND_GROW: begin
				ins_pct = 80;
				del_pct = 10;
			end
			TREND_SHRINK: begin
				ins_pct = 10;
				del_pct = 80;
			end
			default: begin
				ins_pct = 40;
				del_pct = 35;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < ins_pct) begin
			case ($urandom_range(2))
				0: op = ilid_pkg::OP_INS_HEAD;
				1: op = ilid_pkg::OP_INS_TAIL;
				default: op = ilid_pkg::OP_INS_AT;
			endcase
			if ($urandom_range(9) != 0)
				pos = ilid_pkg::POS_W'($urandom_range(list_len));
		end else begin
			op = (roll < ins_pct + del_pct) ? ilid_pkg::OP_DELETE : ilid_pkg::OP_READ;
			if (list_len > 0 && $urandom_range(9) != 0)
				pos = ilid_pkg::POS_W'($urandom_range(list_len - 1));
		end
	endfunction

	// Offer one op beat from a falling edge, idling first at the current rate; once
	// accepted, advance the model and queue the result it calls for.
	task automatic offer_beat(input logic [ilid_pkg::OP_W-1:0] op,
			input logic [ilid_pkg::POS_W-1:0] pos, input logic [ilid_pkg::VAL_W-1:0] v,
			input logic fixed, input list_result_t fixed_result);
		list_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {v, pos};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_list_op(op, pos, v);
		pending_results.push_back(fixed ? fixed_result : predicted);
		op_beats++;
		if (predicted.status == ilid_pkg::ST_FULL)
			full_drops++;
		if (predicted.status == ilid_pkg::ST_RANGE)
			range_ignores++;
		if (list_len > peak_len)
			peak_len = list_len;
		@(negedge clk);
	endtask

	function automatic void report_field(string name, logic [ilid_pkg::VAL_W-1:0] want,
			logic [ilid_pkg::VAL_W-1:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
	endfunction

	// Result side: drop tready at the current idle rate, or hold it off for a long
	// stretch whenever the stimulus asks for pressure.
	always @(negedge clk) begin
		if (pressure_req != pressure_seen) begin
			pressure_seen = pressure_req;
			hold_left = PRESSURE_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare every accepted result beat with the oldest queued one, field by field.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_beats++;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result beat %h with nothing pending", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[ilid_pkg::VAL_W-1:0] !== want.read_value)
					report_field("read_value", want.read_value,
						m_tdata[ilid_pkg::VAL_W-1:0]);
				if (m_tdata[ilid_pkg::VAL_W +: ilid_pkg::ST_W] !== want.status)
					report_field("status", ilid_pkg::VAL_W'(want.status),
						ilid_pkg::VAL_W'(m_tdata[ilid_pkg::VAL_W +: ilid_pkg::ST_W]));
				if (m_tdata[ilid_pkg::VAL_W+ilid_pkg::ST_W +: ilid_pkg::CNT_W] !== want.count)
					report_field("count", ilid_pkg::VAL_W'(want.count),
						ilid_pkg::VAL_W'(
						m_tdata[ilid_pkg::VAL_W+ilid_pkg::ST_W +: ilid_pkg::CNT_W]));
			end
		end
	end

	// Watchdog: end the run if neither port moves a beat for too long.
	always @(posedge clk) begin
		if (s_tvalid && !s_tready)
			backpressure_cycles++;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results pending", $time, quiet_cycles,
				pending_results.size());
			$display("tb_indexed_list_insert_delete: errors");
			$finish;
		end
	end

	initial begin
		logic [ilid_pkg::OP_W-1:0]  op;
		logic [ilid_pkg::POS_W-1:0] pos;
		logic [ilid_pkg::VAL_W-1:0] v;
		int                         send_pcts [3];
		int                         recv_pcts [3];
		int                         drawn;
		send_pcts = '{30, 80, 0};
		recv_pcts = '{80, 30, 0};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ilid_pkg::OP_READ;
		drawn = 0;
		list_len = 0;
		foreach (list_store[i])
			list_store[i] = '0;
		send_idle_pct = send_pcts[0];
		recv_idle_pct = recv_pcts[0];

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows run under the first idle pattern
		for (int r = 0; r < N_DIRECTED; r++)
			offer_beat(DIRECTED[r].op, DIRECTED[r].position, DIRECTED[r].value,
				DIRECTED[r].fixed, DIRECTED[r].result);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_idle_pct = recv_pcts[ph];
			// with the sender at full rate, hold the output off so the block backs up
			if (ph == 2)
				pressure_req++;
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				draw_op(trend_t'((drawn / TREND_LEN) % 3), op, pos, v);
				offer_beat(op, pos, v, 1'b0, '0);
				drawn++;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d op beats (%0d from the table) and checked %0d result beats",
			op_beats, N_DIRECTED, result_beats);
		$display({"list peaked at %0d entries; %0d full drops, %0d out-of-range ops, ",
			"%0d cycles of input back-pressure"},
			peak_len, full_drops, range_ignores, backpressure_cycles);
		if (error_count == 0)
			$display("tb_indexed_list_insert_delete: clean");
		else
			$display("tb_indexed_list_insert_delete: errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ilid_pkg.sv
rtl/core/ilid_list.sv
rtl/core/indexed_list_insert_delete.sv
rtl/core/ilid_checker.sv
bench/tb_indexed_list_insert_delete.sv
